// File: sv/fcim_pkg.sv
// fcim_pkg: shared widths, request tags and structs for the fine/coarse index mapper
// no dependencies; imported by every module of the block
`default_nettype none

package fcim_pkg;

  localparam int IW      = 16;  // index width
  localparam int OW      = 32;  // result width
  localparam int RegIdxW = 2;   // config register index width

  localparam logic [RegIdxW-1:0] REG_SCALE_ONE = RegIdxW'(0);
  localparam logic [RegIdxW-1:0] REG_SCALE_TWO = RegIdxW'(1);

  typedef enum logic [1:0] {
    OP_DOWN,
    OP_UP,
    OP_CFG
  } op_t;

  // partial remainder, dividend/quotient shift register and divisor of one divide cell
  typedef struct packed {
    logic [IW-1:0] r;
    logic [IW-1:0] q;
    logic [IW-1:0] dvs;
  } dstep_t;

  // side band that rides along the divide chain
  typedef struct packed {
    logic            vld;
    op_t             op;
    logic            zero;
    logic [IW:0]     base;
    logic [IW-1:0]   lim;
    logic [2*IW-1:0] prod;
    logic [IW-1:0]   mn;
  } tag_t;

  // derived scale state
  typedef struct packed {
    logic          one_fine;
    logic [IW-1:0] short_step;
    logic [IW-1:0] long_step;
    logic [IW-1:0] rem_count;
    logic [IW:0]   split_point;
    logic [IW-1:0] up_quotient;
  } derived_t;

  // divide request from the config sequencer
  typedef struct packed {
    logic          vld;
    logic [IW-1:0] dividend;
    logic [IW-1:0] divisor;
  } issue_t;

endpackage

`default_nettype wire

// File: sv/fine_coarse_index_mapper_top.sv
// fine_coarse_index_mapper_top: front stage, divide chain and result stage
// depends on fcim_pkg, fcim_config and fcim_div_chain
//
// Maps an index between the scales 0..scale_one_max and 0..scale_two_max.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index 0 selects
// scale_one_max and 1 scale_two_max; other indexes are ignored. Each write
// starts a derivation of the step widths that runs the quotient and
// remainder through the divide chain and then forms the split point;
// busy is high and cfg_ready low meanwhile; when the smaller maximum is
// zero, the divide chain is skipped and all derived values are set to zero.
// Requests: start with command and index_in is taken when busy is low.
// command 0 maps scale one to two, 1 maps scale two to one.
// A new request may be taken in every cycle. Each result passes the
// entry register, the one-bit-per-cell restoring divide chain and the
// result register.
// done is high for one cycle with index_out; the receiver cannot stall.
// Reset clears both maxima and all derived state, so every map gives 0.
`default_nettype none

module fine_coarse_index_mapper_top
  import fcim_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               command,
  input  wire logic [IW-1:0]      index_in,
  output logic                    done,
  output logic [OW-1:0]           index_out,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [RegIdxW-1:0] cfg_index,
  input  wire logic [IW-1:0]      cfg_data
);

  derived_t        derived;
  issue_t          issue;
  dstep_t          front_div;
  tag_t            front_tag;
  dstep_t          chain_div;
  tag_t            chain_tag;
  logic            deriving;
  logic            accept;
  logic            down;
  logic            below_split;
  logic [IW-1:0]   dividend;
  logic [IW-1:0]   divisor;
  logic [2*IW-1:0] prod;
  logic            round_up;
  logic [OW-1:0]   down_res;
  logic [OW-1:0]   up_res;

  assign busy   = deriving;
  assign accept = start && !busy;

  fcim_config u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .chain_div (chain_div),
    .chain_tag (chain_tag),
    .issue     (issue),
    .derived   (derived),
    .deriving  (deriving)
  );

  // front: pick direction, segment and divisor
  always_comb begin
    down        = command ? !derived.one_fine : derived.one_fine;
    below_split = {1'b0, index_in} <= derived.split_point;
    dividend    = below_split ? index_in : index_in - derived.split_point[IW-1:0];
    divisor     = below_split ? derived.long_step : derived.short_step;
    prod        = (2*IW)'(index_in) * (2*IW)'(derived.up_quotient);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_tag.vld <= 1'b0;
    end else begin
      front_tag.vld <= accept || issue.vld;
    end
    if (accept) begin
      front_div.r   <= '0;
      front_div.q   <= dividend;
      front_div.dvs <= divisor;
      front_tag.op  <= down ? OP_DOWN : OP_UP;
      front_tag.zero <= (derived.short_step == '0);
      front_tag.base <= below_split ? '0 : {1'b0, derived.rem_count};
      front_tag.lim  <= divisor >> 1;
      front_tag.prod <= prod;
      front_tag.mn   <= (index_in >= derived.rem_count) ? derived.rem_count : index_in;
    end else begin
      front_div.r    <= '0;
      front_div.q    <= issue.dividend;
      front_div.dvs  <= issue.divisor;
      front_tag.op   <= OP_CFG;
      front_tag.zero <= 1'b0;
      front_tag.base <= '0;
      front_tag.lim  <= '0;
      front_tag.prod <= '0;
      front_tag.mn   <= '0;
    end
  end

  fcim_div_chain u_chain (
    .clk     (clk),
    .rst     (rst),
    .div_in  (front_div),
    .tag_in  (front_tag),
    .div_out (chain_div),
    .tag_out (chain_tag)
  );

  // result: round on the leftover, or finish the upward map
  always_comb begin
    round_up = chain_div.r > chain_tag.lim;
    down_res = OW'(chain_tag.base) + OW'(chain_div.q) + OW'(round_up);
    up_res   = OW'(chain_tag.prod) + OW'(chain_tag.mn);
  end

  always_ff @(posedge clk) begin
    if (chain_tag.op == OP_UP) begin
      index_out <= up_res;
    end else if (chain_tag.zero) begin
      index_out <= '0;
    end else begin
      index_out <= down_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= chain_tag.vld && (chain_tag.op != OP_CFG);
    end
  end

endmodule

`default_nettype wire

// File: sv/fcim_div_cell.sv
// fcim_div_cell: one restoring divide step, registered, with its side band
// depends on fcim_pkg
`default_nettype none

module fcim_div_cell
  import fcim_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire dstep_t div_in,
  input  wire tag_t   tag_in,
  output dstep_t      div_out,
  output tag_t        tag_out
);

  logic [IW:0]   trial;
  logic [IW:0]   diff;
  logic          ge;
  dstep_t        div_next;

  always_comb begin
    trial         = {div_in.r, div_in.q[IW-1]};
    diff          = trial - {1'b0, div_in.dvs};
    ge            = trial >= {1'b0, div_in.dvs};
    div_next.r    = ge ? diff[IW-1:0] : trial[IW-1:0];
    div_next.q    = {div_in.q[IW-2:0], ge};
    div_next.dvs  = div_in.dvs;
  end

  always_ff @(posedge clk) begin
    div_out <= div_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.vld <= 1'b0;
    end else begin
      tag_out <= tag_in;
    end
  end

endmodule

`default_nettype wire

// File: sv/fcim_div_chain.sv
// fcim_div_chain: row of IW divide cells, one quotient bit per cell
// depends on fcim_pkg and fcim_div_cell
`default_nettype none

module fcim_div_chain
  import fcim_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire dstep_t div_in,
  input  wire tag_t   tag_in,
  output dstep_t      div_out,
  output tag_t        tag_out
);

  dstep_t div_link [IW+1];
  tag_t   tag_link [IW+1];

  assign div_link[0] = div_in;
  assign tag_link[0] = tag_in;

  for (genvar k = 0; k < IW; k++) begin : g_cell
    fcim_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .div_in  (div_link[k]),
      .tag_in  (tag_link[k]),
      .div_out (div_link[k+1]),
      .tag_out (tag_link[k+1])
    );
  end

  assign div_out = div_link[IW];
  assign tag_out = tag_link[IW];

endmodule

`default_nettype wire

// File: sv/fcim_config.sv
// fcim_config: scale registers and the sequencer that derives step widths
// depends on fcim_pkg; borrows the divide chain through the issue request
`default_nettype none

module fcim_config
  import fcim_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [RegIdxW-1:0] cfg_index,
  input  wire logic [IW-1:0]      cfg_data,
  input  wire dstep_t             chain_div,
  input  wire tag_t               chain_tag,
  output issue_t                  issue,
  output derived_t                derived,
  output logic                    deriving
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_SPLIT
  } state_t;

  state_t          state;
  logic [IW-1:0]   scale_one;
  logic [IW-1:0]   scale_two;
  logic [IW-1:0]   fine;
  logic [IW-1:0]   coarse;
  logic [IW-1:0]   short_step;
  logic [IW-1:0]   long_step;
  logic [IW-1:0]   rem_count;
  logic [IW:0]     split_point;
  logic [IW-1:0]   up_quotient;
  logic [2*IW-1:0] split_full;
  logic            one_fine;

  // equal maxima count as scale two being fine
  assign one_fine   = scale_one > scale_two;
  assign fine       = one_fine ? scale_one : scale_two;
  assign coarse     = one_fine ? scale_two : scale_one;
  assign split_full = (2*IW)'(rem_count) * (2*IW)'(long_step);

  assign cfg_ready      = (state == S_IDLE);
  assign deriving       = (state != S_IDLE);
  assign issue.vld      = (state == S_ISSUE) && (coarse != '0);
  assign issue.dividend = fine;
  assign issue.divisor  = coarse;

  assign derived.one_fine    = one_fine;
  assign derived.short_step  = short_step;
  assign derived.long_step   = long_step;
  assign derived.rem_count   = rem_count;
  assign derived.split_point = split_point;
  assign derived.up_quotient = up_quotient;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      scale_one   <= '0;
      scale_two   <= '0;
      short_step  <= '0;
      long_step   <= '0;
      rem_count   <= '0;
      split_point <= '0;
      up_quotient <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            unique case (cfg_index)
              REG_SCALE_ONE: begin
                scale_one <= cfg_data;
                state     <= S_ISSUE;
              end
              REG_SCALE_TWO: begin
                scale_two <= cfg_data;
                state     <= S_ISSUE;
              end
              default: ;
            endcase
          end
        end
        S_ISSUE: begin
          if (coarse == '0) begin
            // zero coarse scale: everything derived is zero
            short_step  <= '0;
            long_step   <= '0;
            rem_count   <= '0;
            split_point <= '0;
            up_quotient <= '0;
            state       <= S_IDLE;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (chain_tag.vld && (chain_tag.op == OP_CFG)) begin
            short_step  <= chain_div.q;
            up_quotient <= chain_div.q;
            rem_count   <= chain_div.r;
            long_step   <= chain_div.q + {{(IW-1){1'b0}}, (chain_div.r != '0)};
            state       <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          split_point <= split_full[IW:0];
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
